// File: design/hvss_pkg.sv
// ----------------------------------------------------------------------------
// hvss_pkg: shared types and constants for the soft-start ramp controller
// Holds the transfer payload structures, the action and phase codes, the
// register map and the register reset values.
// ----------------------------------------------------------------------------
package hvss_pkg;

	// Payload of one input transfer.
	typedef struct packed {
		logic [1:0] action;
		logic [9:0] adc_sample;
		logic [9:0] duty_request;
	} in_item_t;

	// Payload of one result transfer.
	typedef struct packed {
		logic       pwm_enabled;
		logic [9:0] duty_value;
		logic [2:0] phase;
		logic       trip_event;
	} out_item_t;

	// Actions carried by an input item.
	typedef enum logic [1:0] {
		ACT_TICK      = 2'd0,
		ACT_SET_DUTY  = 2'd1,
		ACT_FORCE_OFF = 2'd2,
		ACT_RAMP_DOWN = 2'd3
	} action_t;

	// Phase codes as they appear on the result.
	localparam logic [2:0] PHASE_CODE_OFF      = 3'd0;
	localparam logic [2:0] PHASE_CODE_RAMP_UP  = 3'd1;
	localparam logic [2:0] PHASE_CODE_RAMP_DN  = 3'd2;
	localparam logic [2:0] PHASE_CODE_SHUTDOWN = 3'd3;
	localparam logic [2:0] PHASE_CODE_ADJUSTED = 3'd4;

	// Internal phase state, one-hot.
	typedef enum logic [4:0] {
		PH_OFF      = 5'b00001,
		PH_RAMP_UP  = 5'b00010,
		PH_RAMP_DN  = 5'b00100,
		PH_SHUTDOWN = 5'b01000,
		PH_ADJUSTED = 5'b10000
	} phase_t;

	// Register indexes (byte address divided by four).
	localparam logic [2:0] REG_OV_LIMIT   = 3'd0;
	localparam logic [2:0] REG_DUTY_MIN_V = 3'd1;
	localparam logic [2:0] REG_DUTY_MAX_V = 3'd2;
	localparam logic [2:0] REG_DUTY_TGT   = 3'd3;
	localparam logic [2:0] REG_DUTY_STEP  = 3'd4;
	localparam logic [2:0] REG_PWM_PERIOD = 3'd5;

	// Register reset values.
	localparam logic [9:0]  RST_OV_LIMIT   = 10'd1023;
	localparam logic [9:0]  RST_DUTY_MIN_V = 10'd1023;
	localparam logic [9:0]  RST_DUTY_MAX_V = 10'd0;
	localparam logic [9:0]  RST_DUTY_TGT   = 10'd1023;
	localparam logic [9:0]  RST_DUTY_STEP  = 10'd1;
	localparam logic [19:0] RST_PWM_PERIOD = 20'd1000;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic [9:0]  ov_limit;
		logic [9:0]  duty_min_v;
		logic [9:0]  duty_max_v;
		logic [9:0]  duty_tgt;
		logic [9:0]  duty_step;
		logic [19:0] pwm_period;
	} cfg_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		unique case (ph)
			PH_OFF:      code = PHASE_CODE_OFF;
			PH_RAMP_UP:  code = PHASE_CODE_RAMP_UP;
			PH_RAMP_DN:  code = PHASE_CODE_RAMP_DN;
			PH_SHUTDOWN: code = PHASE_CODE_SHUTDOWN;
			PH_ADJUSTED: code = PHASE_CODE_ADJUSTED;
			default:     code = PHASE_CODE_OFF;
		endcase
		return code;
	endfunction

endpackage

// File: design/hv_softstart_ramp_controller.sv
// ----------------------------------------------------------------------------
// hv_softstart_ramp_controller: high-voltage supply soft-start controller
// Overvoltage shutdown, ramp up and ramp down of the PWM duty, direct duty
// setting and forced drive-off, one result per input item.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ---------------------------
//  in        into       in_valid / in_stall       in_data  (in_item_t)
//  out       out of     out_valid / out_stall     out_data (out_item_t)
//  config    into       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// Each item's next state and result are worked out combinationally by the
// compare, add and clamp logic in hvss_core and registered into the result
// register, or into the skid entry when the output side stalls, so an item
// may be accepted on every cycle while in_stall is low. Reset clears the
// phase to off, the duty to zero, the drive to off and both result entries
// to empty. When the output side stalls, one further item is held in the
// skid entry; in_stall then rises and stays high until the result register
// has been taken and the held item has moved up into it.
// ----------------------------------------------------------------------------
module hv_softstart_ramp_controller import hvss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Input item channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	// Result channel.
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t      cfg;
	out_item_t result;
	logic      in_fire;

	// An input transfer completes when valid is high and the skid entry is free.
	assign in_fire = in_valid & ~in_stall;

	// Configuration registers. They are to be written only while the block is idle,
	// so that the datapath sees them as constant over any item; the block does not enforce this.
	hvss_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Phase machine and duty arithmetic; the state advances on each transfer.
	hvss_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_fire (in_fire),
		.in_item (in_data),
		.result  (result)
	);

	// Result register and skid entry, which decouple the two channels.
	hvss_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.result    (result),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// File: design/hvss_regs.sv
// ----------------------------------------------------------------------------
// hvss_regs: configuration register file
// APB-style slave holding the six configuration registers.
// ----------------------------------------------------------------------------
module hvss_regs import hvss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ov_limit   <= RST_OV_LIMIT;
			cfg_q.duty_min_v <= RST_DUTY_MIN_V;
			cfg_q.duty_max_v <= RST_DUTY_MAX_V;
			cfg_q.duty_tgt   <= RST_DUTY_TGT;
			cfg_q.duty_step  <= RST_DUTY_STEP;
			cfg_q.pwm_period <= RST_PWM_PERIOD;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_OV_LIMIT:   cfg_q.ov_limit   <= pwdata[9:0];
				REG_DUTY_MIN_V: cfg_q.duty_min_v <= pwdata[9:0];
				REG_DUTY_MAX_V: cfg_q.duty_max_v <= pwdata[9:0];
				REG_DUTY_TGT:   cfg_q.duty_tgt   <= pwdata[9:0];
				REG_DUTY_STEP:  cfg_q.duty_step  <= pwdata[9:0];
				REG_PWM_PERIOD: cfg_q.pwm_period <= pwdata[19:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_OV_LIMIT:   prdata = {22'd0, cfg_q.ov_limit};
			REG_DUTY_MIN_V: prdata = {22'd0, cfg_q.duty_min_v};
			REG_DUTY_MAX_V: prdata = {22'd0, cfg_q.duty_max_v};
			REG_DUTY_TGT:   prdata = {22'd0, cfg_q.duty_tgt};
			REG_DUTY_STEP:  prdata = {22'd0, cfg_q.duty_step};
			REG_PWM_PERIOD: prdata = {12'd0, cfg_q.pwm_period};
			default:        prdata = 32'd0;
		endcase
	end

endmodule

// File: design/hvss_core.sv
// ----------------------------------------------------------------------------
// hvss_core: phase machine and duty datapath
// Holds phase, duty and drive state and works out the next state and the
// result of one accepted item combinationally.
// ----------------------------------------------------------------------------
module hvss_core import hvss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_fire,
	input  in_item_t  in_item,
	output out_item_t result
);

	phase_t      phase_q, phase_d;
	logic [9:0]  duty_q, duty_d;
	logic        drive_q, drive_d;
	logic        trip;
	action_t     act;
	logic        over_v;
	logic [10:0] up_sum;
	logic [9:0]  down_val;
	logic [9:0]  set_val;

	assign act    = action_t'(in_item.action);
	assign over_v = in_item.adc_sample >= cfg.ov_limit;
	assign up_sum = {1'b0, duty_q} + {1'b0, cfg.duty_step};

	// Ramping up lowers the duty and stops at zero.
	assign down_val = (duty_q > cfg.duty_step) ? (duty_q - cfg.duty_step) : 10'd0;

	// The upper bound wins when the bounds are inverted.
	always_comb begin
		priority if (in_item.duty_request >= cfg.duty_min_v) begin
			set_val = cfg.duty_min_v;
		end else if (in_item.duty_request <= cfg.duty_max_v) begin
			set_val = cfg.duty_max_v;
		end else begin
			set_val = in_item.duty_request;
		end
	end

	always_comb begin
		phase_d = phase_q;
		duty_d  = duty_q;
		drive_d = drive_q;
		trip    = 1'b0;
		unique case (act)
			ACT_TICK: begin
				if (over_v) begin
					trip    = (phase_q != PH_SHUTDOWN);
					phase_d = PH_SHUTDOWN;
					drive_d = 1'b0;
				end else begin
					unique case (phase_q)
						PH_OFF: begin
							phase_d = PH_RAMP_UP;
							duty_d  = cfg.duty_min_v;
							drive_d = 1'b1;
						end
						PH_RAMP_UP: begin
							if (duty_q > cfg.duty_tgt) begin
								duty_d = down_val;
							end else begin
								phase_d = PH_ADJUSTED;
							end
							drive_d = 1'b1;
						end
						PH_RAMP_DN: begin
							if (duty_q < cfg.duty_min_v) begin
								duty_d = up_sum[10] ? 10'h3FF : up_sum[9:0];
							end else begin
								phase_d = PH_OFF;
							end
							drive_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			ACT_SET_DUTY: begin
				duty_d  = set_val;
				drive_d = 1'b1;
			end
			ACT_FORCE_OFF: begin
				drive_d = 1'b0;
			end
			ACT_RAMP_DOWN: begin
				phase_d = PH_RAMP_DN;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF;
			duty_q  <= 10'd0;
			drive_q <= 1'b0;
		end else if (in_fire) begin
			phase_q <= phase_d;
			duty_q  <= duty_d;
			drive_q <= drive_d;
		end
	end

	assign result.pwm_enabled = drive_d;
	assign result.duty_value  = duty_d;
	assign result.phase       = phase_code(phase_d);
	assign result.trip_event  = trip;

endmodule

// File: design/hvss_outbuf.sv
// ----------------------------------------------------------------------------
// hvss_outbuf: result register with skid stage
// Registers each result and keeps one spare entry so that the input side
// can take one further item while the output side is stalled.
// ----------------------------------------------------------------------------
module hvss_outbuf import hvss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  out_item_t result,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	out_item_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;
	logic      out_fire;

	assign out_fire  = out_valid_q & ~out_stall;
	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_q <= skid_q;
			end
		end else if (in_fire) begin
			if (!out_valid_q || out_fire) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

endmodule
